// File: rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants for the chunked body decoder
// Phase codes, status codes, decoder state and queue entry layout.
// ----------------------------------------------------------------------------
package chd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int DROP_BITS = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int TDATA_BITS = 48;
   localparam int TDATA_PAD = TDATA_BITS - 8 - 2 - DROP_BITS;

   localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = '1;
   localparam logic [SIZE_BITS-1:0] SIZE_SAT = SIZE_LIMIT >> 4;
   localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1);

   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] HEX_TEN = 8'd10;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_DATA     = 3'd1,
      PH_TRAIL    = 3'd2,
      PH_TRAIL_CR = 3'd3,
      PH_DONE     = 3'd4,
      PH_LINE     = 3'd5
   } chd_phase_type;

   typedef enum logic [1:0] {
      STATUS_ZERO_CHUNK = 2'd0,
      STATUS_BOUNDARY   = 2'd1,
      STATUS_UNTERM     = 2'd2,
      STATUS_TRUNCATED  = 2'd3
   } chd_status_type;

   typedef struct packed {
      chd_phase_type        phase;
      logic [SIZE_BITS-1:0] chunk_len;
      logic [SIZE_BITS-1:0] bytes_left;
      logic                 hex_done;
      logic                 cr_seen;
   } chd_state_type;

   localparam chd_state_type STATE_RESET = '{
      phase: PH_START,
      chunk_len: '0,
      bytes_left: '0,
      hex_done: 1'b0,
      cr_seen: 1'b0
   };

   typedef struct packed {
      logic                 has_data;
      logic [7:0]           data_byte;
      logic                 has_status;
      chd_status_type       status;
      logic [DROP_BITS-1:0] drop_count;
   } chd_entry_type;

   // valid flag above a 4-bit digit value
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [7:0] t;
      t = 8'd0;
      hex_digit = 5'd0;
      if (b >= CHAR_0 && b <= CHAR_9) begin
         t = b - CHAR_0;
         hex_digit = {1'b1, t[3:0]};
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
         t = b - CHAR_LOWER_A + HEX_TEN;
         hex_digit = {1'b1, t[3:0]};
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         t = b - CHAR_UPPER_A + HEX_TEN;
         hex_digit = {1'b1, t[3:0]};
      end
   endfunction

endpackage

// File: rtl/chd_core.sv
// ----------------------------------------------------------------------------
// chd_core: chunked framing decode stage
// Registers one body byte, decodes it against the framing state and hands
// a data and/or end status entry to the result queue.
// ----------------------------------------------------------------------------
module chd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            byte_in,
   input  logic                  last_in,
   input  logic                  room,
   output logic                  push,
   output chd_pkg::chd_entry_type entry
);

   logic                   stage_valid_ff;
   logic [7:0]             stage_byte_ff;
   logic                   stage_last_ff;
   chd_pkg::chd_state_type state_ff;
   chd_pkg::chd_state_type state_in;
   chd_pkg::chd_entry_type entry_in;
   logic                   has_work;
   logic                   advance;

   function automatic chd_pkg::chd_state_type size_line(
      input chd_pkg::chd_state_type s,
      input logic [7:0]             b
   );
      chd_pkg::chd_state_type n;
      logic [4:0]             d;
      n = s;
      d = chd_pkg::hex_digit(b);
      if (s.cr_seen && b == chd_pkg::CHAR_LF) begin
         n.hex_done = 1'b0;
         n.cr_seen = 1'b0;
         n.bytes_left = s.chunk_len;
         n.phase = (s.chunk_len == '0) ? chd_pkg::PH_DONE : chd_pkg::PH_DATA;
      end else begin
         if (s.hex_done || !d[4]) begin
            n.hex_done = 1'b1;
         end else if (s.chunk_len > chd_pkg::SIZE_SAT) begin
            n.chunk_len = chd_pkg::SIZE_LIMIT;
         end else begin
            n.chunk_len = {s.chunk_len[chd_pkg::SIZE_BITS-5:0], d[3:0]};
         end
         n.cr_seen = (b == chd_pkg::CHAR_CR);
         n.phase = chd_pkg::PH_LINE;
      end
      return n;
   endfunction

   always_comb begin
      state_in = state_ff;
      entry_in = '0;
      case (state_ff.phase)
         chd_pkg::PH_DATA: begin
            entry_in.has_data = 1'b1;
            entry_in.data_byte = stage_byte_ff;
            if (state_in.bytes_left != '0) begin
               state_in.bytes_left = state_in.bytes_left - chd_pkg::SIZE_ONE;
            end
            if (state_in.bytes_left == '0) begin
               state_in.phase = chd_pkg::PH_TRAIL;
            end
         end
         chd_pkg::PH_TRAIL: begin
            if (stage_byte_ff == chd_pkg::CHAR_CR) begin
               state_in.phase = chd_pkg::PH_TRAIL_CR;
            end else begin
               state_in.chunk_len = '0;
               state_in.hex_done = 1'b0;
               state_in.cr_seen = 1'b0;
               state_in = size_line(state_in, stage_byte_ff);
            end
         end
         chd_pkg::PH_TRAIL_CR: begin
            if (stage_byte_ff == chd_pkg::CHAR_LF) begin
               state_in.phase = chd_pkg::PH_START;
               state_in.chunk_len = '0;
               state_in.hex_done = 1'b0;
               state_in.cr_seen = 1'b0;
            end else begin
               // stray cr opens the next size line
               state_in.chunk_len = '0;
               state_in.hex_done = 1'b1;
               state_in.cr_seen = 1'b1;
               state_in.phase = chd_pkg::PH_LINE;
               state_in = size_line(state_in, stage_byte_ff);
            end
         end
         chd_pkg::PH_DONE: begin
            state_in = state_ff;
         end
         chd_pkg::PH_LINE: begin
            state_in = size_line(state_in, stage_byte_ff);
         end
         default: begin
            state_in.chunk_len = '0;
            state_in.hex_done = 1'b0;
            state_in.cr_seen = 1'b0;
            state_in = size_line(state_in, stage_byte_ff);
         end
      endcase

      if (stage_last_ff) begin
         entry_in.has_status = 1'b1;
         case (state_in.phase)
            chd_pkg::PH_DONE: begin
               entry_in.status = chd_pkg::STATUS_ZERO_CHUNK;
            end
            chd_pkg::PH_DATA: begin
               entry_in.status = chd_pkg::STATUS_TRUNCATED;
               entry_in.drop_count =
                  chd_pkg::DROP_BITS'(state_in.chunk_len - state_in.bytes_left);
            end
            chd_pkg::PH_LINE, chd_pkg::PH_TRAIL_CR: begin
               entry_in.status = chd_pkg::STATUS_UNTERM;
            end
            default: begin
               entry_in.status = chd_pkg::STATUS_BOUNDARY;
            end
         endcase
         state_in = chd_pkg::STATE_RESET;
      end
   end

   assign has_work = entry_in.has_data || entry_in.has_status;
   assign advance = !stage_valid_ff || !has_work || room;
   assign req_tready = advance;
   assign push = stage_valid_ff && has_work && room;
   assign entry = entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         state_ff <= chd_pkg::STATE_RESET;
      end else begin
         if (stage_valid_ff && advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            stage_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && advance) begin
         stage_byte_ff <= byte_in;
         stage_last_ff <= last_in;
      end
   end

endmodule

// File: rtl/chd_outq.sv
// ----------------------------------------------------------------------------
// chd_outq: result queue
// Two-entry queue of decoded entries; each entry leaves as a data
// transaction, an end status transaction, or both in that order.
// ----------------------------------------------------------------------------
module chd_outq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  chd_pkg::chd_entry_type             entry,
   output logic                               room,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [chd_pkg::TDATA_BITS-1:0]     rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   chd_pkg::chd_entry_type entries_ff [chd_pkg::QUEUE_DEPTH];
   logic                   wr_ptr_ff;
   logic                   wr_ptr_in;
   logic                   rd_ptr_ff;
   logic                   rd_ptr_in;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic                   part_ff;
   logic                   part_in;
   chd_pkg::chd_entry_type head;
   logic                   show_data;
   logic                   taken;
   logic                   pop;

   assign head = entries_ff[rd_ptr_ff];
   assign show_data = !part_ff && head.has_data;
   assign room = (count_ff != 2'(chd_pkg::QUEUE_DEPTH));
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser = show_data ? chd_pkg::KIND_DATA : chd_pkg::KIND_STATUS;
   assign rsp_tlast = !show_data;
   assign rsp_tdata = show_data
      ? {{chd_pkg::TDATA_PAD{1'b0}}, {chd_pkg::DROP_BITS{1'b0}}, 2'b00, head.data_byte}
      : {{chd_pkg::TDATA_PAD{1'b0}}, head.drop_count, head.status, 8'h00};

   assign taken = rsp_tvalid && rsp_tready;
   assign pop = taken && (!show_data || !head.has_status);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      part_in = part_ff;
      if (pop) begin
         part_in = 1'b0;
      end else if (taken) begin
         part_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
         part_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: rtl/http_chunked_decoder_top.sv
// path: an accepted byte goes into the core stage register, and its decoded entry into
//   the result queue, from which its first result transaction is offered
// throughput: one byte per cycle while the result queue has room; a final byte that also
//   carries data gives two transactions, which the single result port sends one after the other
// the two-entry result queue lets input continue while results wait
// reset: synchronous, active high; clears framing state, stage and queue
// ----------------------------------------------------------------------------
// http_chunked_decoder_top: chunked transfer body decoder
// Strips chunk size lines and trailers from a body byte stream and reports
// how the body ended on its final byte.
// ----------------------------------------------------------------------------
module http_chunked_decoder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // in_byte[7:0]
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [chd_pkg::TDATA_BITS-1:0] rsp_tdata,   // out_byte[7:0], end_status[9:8],
                                                       // drop_count[41:10], zeros[47:42]
   output logic                           rsp_tuser,   // out_kind
   output logic                           rsp_tlast
);

   logic                   push;
   logic                   room;
   chd_pkg::chd_entry_type entry;

   chd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .byte_in    (req_tdata),
      .last_in    (req_tlast),
      .room       (room),
      .push       (push),
      .entry      (entry)
   );

   chd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .entry      (entry),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("entry pushed into a full result queue");

   a_drop_only_truncated: assert property (@(posedge clock) disable iff (reset)
      (push && (!entry.has_status || entry.status != chd_pkg::STATUS_TRUNCATED))
      |-> entry.drop_count == '0)
      else $error("drop count set outside a truncated chunk");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == chd_pkg::KIND_STATUS)
      |-> (rsp_tlast && rsp_tdata[7:0] == 8'h00))
      else $error("status transaction malformed");

   a_data_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == chd_pkg::KIND_DATA)
      |-> (!rsp_tlast && rsp_tdata[chd_pkg::TDATA_BITS-1:8] == '0))
      else $error("data transaction malformed");

endmodule
